[hw/rtl/rfb_pkg.sv]
// shared types, constants and helper functions for the replica failover block
// no dependencies; used by rfb_backoff_unit and replica_failover_with_backoff
`timescale 1ns / 1ps
`default_nettype none

package rfb_pkg;

   localparam int unsigned PEER_TOTAL   = 16;
   localparam int unsigned PEER_W       = 4;
   localparam int unsigned SHARD_TOTAL  = 4;
   localparam int unsigned MAX_REPLICAS = 4;

   // configuration register indexes
   localparam logic [1:0] CSR_REPLICA_MAP    = 2'd0;
   localparam logic [1:0] CSR_REPLICA_COUNTS = 2'd1;
   localparam logic [1:0] CSR_MAX_BACKOFF    = 2'd2;

   localparam logic [15:0] MAX_BACKOFF_RESET = 16'd600;

   // request op codes
   localparam logic OP_SELECT = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   localparam logic [7:0]  FAIL_COUNT_MAX = 8'hFF;
   localparam logic [2:0]  TRIED_MAX      = 3'd7;
   // top digit weight of the root search over a 24-bit cube
   localparam logic [23:0] ROOT_FIRST_BIT = 24'h40_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_REPORT,
      ST_BACKOFF,
      ST_FINISH
   } rfb_state_type;

   typedef enum logic [2:0] {
      BO_IDLE,
      BO_MUL_SQ,
      BO_MUL_CUBE,
      BO_ROOT,
      BO_DONE
   } rfb_bo_state_type;

   typedef struct packed {
      logic        start;
      logic [7:0]  count;
      logic [15:0] cap;
   } rfb_bo_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] backoff;
   } rfb_bo_rsp_type;

   // replica count of a shard, 1..4
   function automatic logic [2:0] shard_count(input logic [7:0] counts,
                                              input logic [1:0] shard);
      return {1'b0, counts[{shard, 1'b0} +: 2]} + 3'd1;
   endfunction

   // small value modulo a replica count of 1..4
   function automatic logic [1:0] mod_count(input logic [2:0] v, input logic [2:0] n);
      logic [2:0] t;
      t = v;
      unique case (n)
         3'd1: t = 3'd0;
         3'd2: t = {2'b00, v[0]};
         3'd3: begin
            t = (v >= 3'd3) ? v - 3'd3 : v;
            t = (t >= 3'd3) ? t - 3'd3 : t;
         end
         default: t = {1'b0, v[1:0]};
      endcase
      return t[1:0];
   endfunction

   // peer id at a slot of a shard's replica list
   function automatic logic [3:0] slot_peer(input logic [63:0] map,
                                            input logic [1:0] shard,
                                            input logic [1:0] slot);
      return map[{shard, slot, 2'b00} +: 4];
   endfunction

endpackage

`default_nettype wire

[hw/rtl/rfb_backoff_unit.sv]
// backoff calculator: min(floor(count^1.5), cap) as isqrt(count^3)
// one shared 16x8 multiplier for the cube, then one root digit per cycle; uses rfb_pkg
`timescale 1ns / 1ps
`default_nettype none

module rfb_backoff_unit (
   input  wire                          clock,
   input  wire                          reset,
   input  wire rfb_pkg::rfb_bo_req_type bo_req,
   output rfb_pkg::rfb_bo_rsp_type      bo_rsp
);

   rfb_pkg::rfb_bo_state_type state_ff, state_in;

   logic [7:0]  count_ff, count_in;
   logic [15:0] cap_ff, cap_in;
   logic [23:0] prod_ff, prod_in;
   logic [23:0] rem_ff, rem_in;
   logic [23:0] root_ff, root_in;
   logic [23:0] bit_ff, bit_in;

   logic [15:0] mul_a;
   logic [23:0] mul_p;
   logic [23:0] trial;

   // shared multiplier: count*count, then square*count
   assign mul_a = (state_ff == rfb_pkg::BO_MUL_CUBE) ? prod_ff[15:0] : {8'b0, count_ff};
   assign mul_p = {8'b0, mul_a} * {16'b0, count_ff};
   assign trial = root_ff + bit_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rfb_pkg::BO_IDLE:     if (bo_req.start) state_in = rfb_pkg::BO_MUL_SQ;
         rfb_pkg::BO_MUL_SQ:   state_in = rfb_pkg::BO_MUL_CUBE;
         rfb_pkg::BO_MUL_CUBE: state_in = rfb_pkg::BO_ROOT;
         rfb_pkg::BO_ROOT:     if (bit_ff == 24'd1) state_in = rfb_pkg::BO_DONE;
         rfb_pkg::BO_DONE:     state_in = rfb_pkg::BO_IDLE;
         default:              state_in = rfb_pkg::BO_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      cap_in   = cap_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      unique case (state_ff)
         rfb_pkg::BO_IDLE: begin
            if (bo_req.start) begin
               count_in = bo_req.count;
               cap_in   = bo_req.cap;
            end
         end
         rfb_pkg::BO_MUL_SQ: prod_in = mul_p;
         rfb_pkg::BO_MUL_CUBE: begin
            rem_in  = mul_p;
            root_in = '0;
            bit_in  = rfb_pkg::ROOT_FIRST_BIT;
         end
         rfb_pkg::BO_ROOT: begin
            if (rem_ff >= trial) begin
               rem_in  = rem_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         default: ;
      endcase
      bo_rsp.done    = (state_ff == rfb_pkg::BO_DONE);
      bo_rsp.backoff = (root_ff[15:0] < cap_ff) ? root_ff[15:0] : cap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rfb_pkg::BO_IDLE;
      end else begin
         state_ff <= state_in;
      end
      count_ff <= count_in;
      cap_ff   <= cap_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      bit_ff   <= bit_in;
   end

endmodule

`default_nettype wire

[hw/rtl/replica_failover_with_backoff.sv]
// top level: replica selection with per-peer fail counts and retry times
// depends on rfb_pkg and rfb_backoff_unit
`timescale 1ns / 1ps
`default_nettype none

// usage
//   req_* beat: op select walks the shard's replica list from req_cursor_in and
//   returns the first peer whose retry time is not after req_time_seconds;
//   op report records an attempt outcome on the cursor's peer
//   rsp_* beat: one result per request, in request order
//   csr_*: write-only register port, taken at any edge with csr_write_en high;
//   write only while no request is in flight
// sequencing (result valid from the same cycle in which req_ready rises again)
//   one request at a time; req_ready is high only while the sequencer is idle
//   select: the walk state checks the replicas against the retry table one by
//   one, and ends once the list runs out when every replica is in backoff
//   report success: straight to finish; report failure: waits on the
//   backoff unit (two passes of its multiplier, then 12 root digit steps)
// reset
//   sync, active high: fail counts and retry times cleared, map and counts 0,
//   max backoff 600
// stall
//   the result sits in an output register; the next request is accepted while
//   it waits, and that request's result waits in the sequencer until it frees

module replica_failover_with_backoff (
   input  wire         clock,
   input  wire         reset,

   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_op,
   input  wire  [1:0]  req_shard,
   input  wire  [1:0]  req_cursor_in,
   input  wire  [2:0]  req_tried_in,
   input  wire         req_attempt_failed,
   input  wire  [31:0] req_time_seconds,

   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [3:0]  rsp_peer_id,
   output logic [1:0]  rsp_cursor_out,
   output logic [2:0]  rsp_tried_out,
   output logic        rsp_none_healthy,
   output logic [15:0] rsp_backoff_seconds,

   input  wire         csr_write_en,
   input  wire  [1:0]  csr_index,
   input  wire  [63:0] csr_wdata
);

   // config registers
   logic [63:0] replica_map_ff;
   logic [7:0]  replica_counts_ff;
   logic [15:0] max_backoff_ff;

   // per-peer health table
   logic [7:0]  fail_ff  [rfb_pkg::PEER_TOTAL];
   logic [31:0] retry_ff [rfb_pkg::PEER_TOTAL];

   rfb_pkg::rfb_state_type state_ff, state_in;

   // request context held by the sequencer
   logic        op_ff, op_in;
   logic [1:0]  shard_ff, shard_in;
   logic [2:0]  cur_ff, cur_in;       // may run past the list end while walking
   logic [2:0]  tried_ff, tried_in;
   logic        failed_ff, failed_in;
   logic [31:0] now_ff, now_in;
   logic [3:0]  peer_ff, peer_in;
   logic        found_ff, found_in;
   logic [15:0] backoff_ff, backoff_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_peer_ff, rsp_peer_in;
   logic [1:0]  rsp_cursor_ff, rsp_cursor_in;
   logic [2:0]  rsp_tried_ff, rsp_tried_in;
   logic        rsp_none_ff, rsp_none_in;
   logic [15:0] rsp_backoff_ff, rsp_backoff_in;

   // table write controls
   logic        fail_we, retry_we;
   logic [7:0]  fail_wdata;
   logic [31:0] retry_wdata;

   rfb_pkg::rfb_bo_req_type bo_req;
   rfb_pkg::rfb_bo_rsp_type bo_rsp;

   logic        req_accept;
   logic [2:0]  n_cur;
   logic [7:0]  cur_fail;
   logic [31:0] cur_retry;
   logic        walk_live;
   logic        walk_hit;
   logic        out_free;
   logic [2:0]  cur_base;

   assign req_ready  = (state_ff == rfb_pkg::ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign n_cur      = rfb_pkg::shard_count(replica_counts_ff, shard_ff);
   assign cur_fail   = fail_ff[peer_ff];
   assign cur_retry  = retry_ff[peer_ff];
   // walk compare: request time against the current peer's retry time
   assign walk_live  = (tried_ff < n_cur);
   assign walk_hit   = walk_live && (now_ff >= cur_retry);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign cur_base   = {1'b0, rfb_pkg::mod_count(cur_ff, n_cur)};

   rfb_backoff_unit u_backoff (
      .clock  (clock),
      .reset  (reset),
      .bo_req (bo_req),
      .bo_rsp (bo_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rfb_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_op == rfb_pkg::OP_SELECT) ? rfb_pkg::ST_WALK
                                                         : rfb_pkg::ST_REPORT;
            end
         end
         rfb_pkg::ST_WALK: begin
            if (!walk_live || walk_hit) state_in = rfb_pkg::ST_FINISH;
         end
         rfb_pkg::ST_REPORT: begin
            state_in = failed_ff ? rfb_pkg::ST_BACKOFF : rfb_pkg::ST_FINISH;
         end
         rfb_pkg::ST_BACKOFF: begin
            if (bo_rsp.done) state_in = rfb_pkg::ST_FINISH;
         end
         rfb_pkg::ST_FINISH: begin
            if (out_free) state_in = rfb_pkg::ST_IDLE;
         end
         default: state_in = rfb_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in      = op_ff;
      shard_in   = shard_ff;
      cur_in     = cur_ff;
      tried_in   = tried_ff;
      failed_in  = failed_ff;
      now_in     = now_ff;
      peer_in    = peer_ff;
      found_in   = found_ff;
      backoff_in = backoff_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_peer_in    = rsp_peer_ff;
      rsp_cursor_in  = rsp_cursor_ff;
      rsp_tried_in   = rsp_tried_ff;
      rsp_none_in    = rsp_none_ff;
      rsp_backoff_in = rsp_backoff_ff;

      fail_we     = 1'b0;
      fail_wdata  = cur_fail;
      retry_we    = 1'b0;
      retry_wdata = '0;

      bo_req.start = 1'b0;
      bo_req.count = cur_fail;
      bo_req.cap   = max_backoff_ff;

      unique case (state_ff)
         rfb_pkg::ST_IDLE: begin
            if (req_accept) begin
               op_in     = req_op;
               shard_in  = req_shard;
               cur_in    = {1'b0, req_cursor_in};
               tried_in  = req_tried_in;
               failed_in = req_attempt_failed;
               now_in    = req_time_seconds;
               found_in  = 1'b0;
               peer_in   = rfb_pkg::slot_peer(replica_map_ff, req_shard,
                              rfb_pkg::mod_count({1'b0, req_cursor_in},
                                 rfb_pkg::shard_count(replica_counts_ff, req_shard)));
            end
         end
         rfb_pkg::ST_WALK: begin
            if (walk_hit) begin
               // peer out of backoff: take it and clear its retry time
               retry_we = 1'b1;
               found_in = 1'b1;
            end else if (walk_live) begin
               tried_in = tried_ff + 3'd1;
               cur_in   = cur_ff + 3'd1;
               peer_in  = rfb_pkg::slot_peer(replica_map_ff, shard_ff,
                             rfb_pkg::mod_count(cur_ff + 3'd1, n_cur));
            end
         end
         rfb_pkg::ST_REPORT: begin
            fail_we = 1'b1;
            if (failed_ff) begin
               fail_wdata   = (cur_fail == rfb_pkg::FAIL_COUNT_MAX) ? cur_fail
                                                                  : cur_fail + 8'd1;
               cur_in       = cur_base + 3'd1;
               tried_in     = (tried_ff == rfb_pkg::TRIED_MAX) ? tried_ff : tried_ff + 3'd1;
               bo_req.start = 1'b1;
               bo_req.count = fail_wdata;
            end else begin
               fail_wdata = (cur_fail == 8'd0) ? cur_fail : cur_fail - 8'd1;
               retry_we   = 1'b1;
               cur_in     = cur_base;
               backoff_in = '0;
            end
         end
         rfb_pkg::ST_BACKOFF: begin
            if (bo_rsp.done) begin
               retry_we    = 1'b1;
               retry_wdata = now_ff + {16'b0, bo_rsp.backoff};
               backoff_in  = bo_rsp.backoff;
            end
         end
         rfb_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_peer_in    = peer_ff;
               rsp_cursor_in  = rfb_pkg::mod_count(cur_ff, n_cur);
               rsp_tried_in   = tried_ff;
               rsp_none_in    = (op_ff == rfb_pkg::OP_SELECT) && !found_ff;
               rsp_backoff_in = ((op_ff == rfb_pkg::OP_REPORT) && failed_ff) ? backoff_ff
                                                                             : 16'd0;
            end
         end
         default: ;
      endcase
   end

   // control state, config and health table
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= rfb_pkg::ST_IDLE;
         rsp_valid_ff      <= 1'b0;
         replica_map_ff    <= '0;
         replica_counts_ff <= '0;
         max_backoff_ff    <= rfb_pkg::MAX_BACKOFF_RESET;
         for (int i = 0; i < rfb_pkg::PEER_TOTAL; i++) begin
            fail_ff[i]  <= '0;
            retry_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               rfb_pkg::CSR_REPLICA_MAP:    replica_map_ff    <= csr_wdata;
               rfb_pkg::CSR_REPLICA_COUNTS: replica_counts_ff <= csr_wdata[7:0];
               rfb_pkg::CSR_MAX_BACKOFF:    max_backoff_ff    <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (fail_we)  fail_ff[peer_ff]  <= fail_wdata;
         if (retry_we) retry_ff[peer_ff] <= retry_wdata;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      shard_ff       <= shard_in;
      cur_ff         <= cur_in;
      tried_ff       <= tried_in;
      failed_ff      <= failed_in;
      now_ff         <= now_in;
      peer_ff        <= peer_in;
      found_ff       <= found_in;
      backoff_ff     <= backoff_in;
      rsp_peer_ff    <= rsp_peer_in;
      rsp_cursor_ff  <= rsp_cursor_in;
      rsp_tried_ff   <= rsp_tried_in;
      rsp_none_ff    <= rsp_none_in;
      rsp_backoff_ff <= rsp_backoff_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_peer_id         = rsp_peer_ff;
   assign rsp_cursor_out      = rsp_cursor_ff;
   assign rsp_tried_out       = rsp_tried_ff;
   assign rsp_none_healthy    = rsp_none_ff;
   assign rsp_backoff_seconds = rsp_backoff_ff;

endmodule

`default_nettype wire
